// ===== design/bt_pkg.sv =====
package bt_pkg;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_Z     = 2'd1;
	localparam status_t ST_BAD_GEOM = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BEACON_TWO_X   = 3'd0;
	localparam cfg_idx_t CFG_BEACON_THREE_X = 3'd1;
	localparam cfg_idx_t CFG_BEACON_THREE_Y = 3'd2;
	localparam cfg_idx_t CFG_BEACON_FOUR_X  = 3'd3;
	localparam cfg_idx_t CFG_BEACON_FOUR_Y  = 3'd4;
	localparam cfg_idx_t CFG_BEACON_FOUR_Z  = 3'd5;
	localparam cfg_idx_t CFG_USE_FOURTH     = 3'd6;

endpackage

// ===== design/bt_if.sv =====
interface bt_in_if #(parameter int W = 32) ();
	logic         valid;
	logic         ready;
	logic [W-2:0] dist_one;
	logic [W-2:0] dist_two;
	logic [W-2:0] dist_three;
	logic [W-2:0] dist_four;

	modport source (output valid, dist_one, dist_two, dist_three, dist_four, input ready);
	modport sink   (input valid, dist_one, dist_two, dist_three, dist_four, output ready);
endinterface

interface bt_out_if #(parameter int W = 32) ();
	logic                signed [W-1:0] pos_x;
	logic                signed [W-1:0] pos_y;
	logic                signed [W-1:0] pos_z;
	bt_pkg::status_t                    status;
	logic                               valid;
	logic                               ready;

	modport source (output valid, pos_x, pos_y, pos_z, status, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, status, output ready);
endinterface

interface bt_cfg_if #(parameter int W = 32) ();
	logic             valid;
	logic             ready;
	bt_pkg::cfg_idx_t index;
	logic [W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bt_cfg.sv =====
module bt_cfg #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	bt_cfg_if.sink              cfg,
	output logic signed [W-1:0] two_x,
	output logic signed [W-1:0] three_x,
	output logic signed [W-1:0] three_y,
	output logic signed [W-1:0] four_x,
	output logic signed [W-1:0] four_y,
	output logic signed [W-1:0] four_z,
	output logic                use_fourth
);

	localparam logic [W-1:0] ONE = W'(1) << F;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_x      <= ONE;
			three_x    <= '0;
			three_y    <= ONE;
			four_x     <= '0;
			four_y     <= '0;
			four_z     <= '0;
			use_fourth <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				bt_pkg::CFG_BEACON_TWO_X:   two_x      <= cfg.data;
				bt_pkg::CFG_BEACON_THREE_X: three_x    <= cfg.data;
				bt_pkg::CFG_BEACON_THREE_Y: three_y    <= cfg.data;
				bt_pkg::CFG_BEACON_FOUR_X:  four_x     <= cfg.data;
				bt_pkg::CFG_BEACON_FOUR_Y:  four_y     <= cfg.data;
				bt_pkg::CFG_BEACON_FOUR_Z:  four_z     <= cfg.data;
				bt_pkg::CFG_USE_FOURTH:     use_fourth <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/bt_div.sv =====
module bt_div #(
	parameter int W  = 32,
	parameter int NW = 65,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [NW-1:0] num,
	input  logic signed [W:0]    den,
	input  logic [SW-1:0]        in_side,
	output logic                 out_vld,
	output logic signed [W-1:0]  quo,
	output logic [SW-1:0]        out_side
);

	localparam int CW = NW + W + 1;
	localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

	// magnitudes and sign
	logic          vld_s1;
	logic [NW-1:0] an_s1;
	logic [W:0]    ad_s1;
	logic          neg_s1;
	logic [SW-1:0] side_s1;

	logic [NW-1:0] an_c;
	logic [W:0]    ad_c;
	assign an_c = num[NW-1] ? NW'(NW'(0) - NW'(num)) : NW'(num);
	assign ad_c = den[W] ? (W+1)'((W+1)'(0) - (W+1)'(den)) : (W+1)'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1   <= an_c;
			ad_s1   <= ad_c;
			neg_s1  <= num[NW-1] ^ den[W];
			side_s1 <= in_side;
		end
	end

	// element 0 holds the overflow check, element t+1 the result of quotient bit W-1-t
	logic          vld_s  [0:W];
	logic [NW-1:0] rem_s  [0:W];
	logic [W:0]    ad_s   [0:W];
	logic [W-1:0]  qb_s   [0:W];
	logic          ovf_s  [0:W];
	logic          neg_s  [0:W];
	logic [SW-1:0] side_s [0:W];

	logic [CW-1:0] lim_c;
	assign lim_c = (CW'(ad_s1) << (W-1)) + (neg_s1 ? CW'(ad_s1) : CW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= an_s1;
			ad_s[0]   <= ad_s1;
			qb_s[0]   <= '0;
			ovf_s[0]  <= CW'(an_s1) >= lim_c;
			neg_s[0]  <= neg_s1;
			side_s[0] <= side_s1;
		end
	end

	for (genvar t = 0; t < W; t++) begin : g_step
		localparam int K = W - 1 - t;
		logic [CW-1:0] trial;
		logic          take;
		assign trial = CW'(ad_s[t]) << K;
		assign take  = CW'(rem_s[t]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[t+1] <= 1'b0;
			else if (en) vld_s[t+1] <= vld_s[t];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[t+1]  <= take ? NW'(CW'(rem_s[t]) - trial) : rem_s[t];
				qb_s[t+1]   <= qb_s[t] | (take ? (W'(1) << K) : W'(0));
				ad_s[t+1]   <= ad_s[t];
				ovf_s[t+1]  <= ovf_s[t];
				neg_s[t+1]  <= neg_s[t];
				side_s[t+1] <= side_s[t];
			end
		end
	end

	// sign and saturate
	logic [W-1:0] res_c;
	always_comb begin
		if (ovf_s[W]) res_c = neg_s[W] ? QMIN : QMAX;
		else          res_c = neg_s[W] ? W'(0) - qb_s[W] : qb_s[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= vld_s[W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo      <= res_c;
			out_side <= side_s[W];
		end
	end

endmodule

// ===== design/bt_sqrt.sv =====
module bt_sqrt #(
	parameter int RW = 62,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [RW-1:0]      rad,
	input  logic [SW-1:0]      in_side,
	output logic               out_vld,
	output logic [RW/2-1:0]    root,
	output logic [SW-1:0]      out_side
);

	localparam int QW = RW / 2;

	// one result bit per stage, remainder and partial root travel along
	logic          vld_s  [0:QW-1];
	logic [RW-1:0] rem_s  [0:QW-1];
	logic [RW-1:0] res_s  [0:QW-1];
	logic [SW-1:0] side_s [0:QW-1];

	for (genvar t = 0; t < QW; t++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (QW - 1 - t));
		logic          vld_in;
		logic [RW-1:0] rem_in;
		logic [RW-1:0] res_in;
		logic [SW-1:0] side_in;
		logic [RW-1:0] trial;
		logic          take;

		if (t == 0) begin : g_head
			assign vld_in  = in_vld;
			assign rem_in  = rad;
			assign res_in  = '0;
			assign side_in = in_side;
		end else begin : g_body
			assign vld_in  = vld_s[t-1];
			assign rem_in  = rem_s[t-1];
			assign res_in  = res_s[t-1];
			assign side_in = side_s[t-1];
		end

		assign trial = res_in + BIT;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[t] <= 1'b0;
			else if (en) vld_s[t] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[t]  <= take ? rem_in - trial : rem_in;
				res_s[t]  <= take ? (res_in >> 1) + BIT : res_in >> 1;
				side_s[t] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign root     = res_s[QW-1][QW-1:0];
	assign out_side = side_s[QW-1];

endmodule

// ===== design/beacon_trilateration.sv =====
// Channel   | Dir | Beat carries
// ----------+-----+-----------------------------------------------------
// meas      | in  | dist_one, dist_two, dist_three, dist_four
// position  | out | pos_x, pos_y, pos_z, status
// cfg       | in  | index, data (register write, always ready)
//
// One measurement set enters per cycle while meas is ready; each result beat
// passes through the two bit-per-stage dividers and the bit-per-stage square
// roots for z and for the two parallel beacon-four lanes.
// arst_n clears all valid bits and loads the register reset values.
// The whole pipeline advances on one enable; a two-entry output buffer keeps
// meas ready while one result waits and stalls the pipeline when it is full.
module beacon_trilateration #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bt_in_if.sink       meas,
	bt_out_if.source    position,
	bt_cfg_if.sink      cfg
);

	localparam int W   = WORD_WIDTH;
	localparam int NXW = 2 * W + 1;    // x numerator
	localparam int NYW = 2 * W + 2;    // y numerator
	localparam int SQW = 2 * W - 2;    // square of a distance
	localparam int CQW = 2 * W - 1;    // square of a signed word
	localparam int DQW = 2 * W + 1;    // square of a word difference
	localparam int FRW = 2 * W + 2;    // squared distance to beacon four
	localparam int SXW = NXW + SQW + (W - 1) + 1;
	localparam int SYW = W + SQW + (W - 1) + 1;
	localparam int SZW = 2 * W + (W - 1) + 2;

	// Configuration registers; the user must keep them stable while items are in flight, the block does not enforce it
	logic signed [W-1:0] two_x, three_x, three_y, four_x, four_y, four_z;
	logic                use_fourth;

	bt_cfg #(.W(W), .F(FRAC_BITS)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.two_x      (two_x),
		.three_x    (three_x),
		.three_y    (three_y),
		.four_x     (four_x),
		.four_y     (four_y),
		.four_z     (four_z),
		.use_fourth (use_fourth)
	);

	// Global advance: hold every stage while the output buffer is full
	logic [1:0] cnt_q;
	logic       en;
	assign en         = cnt_q != 2'd2;
	assign meas.ready = en;

	// ---- stage 1: squares of distances and of the beacon geometry
	logic           vld_s1, bad_s1;
	logic [SQW-1:0] r1s_s1, r2s_s1, r3s_s1;
	logic [CQW-1:0] dd_s1, ii_s1, jj_s1;
	logic [W-2:0]   r4_s1;

	logic [SQW-1:0]        r1s_c, r2s_c, r3s_c;
	logic signed [2*W-1:0] dd_c, ii_c, jj_c;
	assign r1s_c = SQW'(meas.dist_one) * SQW'(meas.dist_one);
	assign r2s_c = SQW'(meas.dist_two) * SQW'(meas.dist_two);
	assign r3s_c = SQW'(meas.dist_three) * SQW'(meas.dist_three);
	assign dd_c  = (2*W)'(two_x) * (2*W)'(two_x);
	assign ii_c  = (2*W)'(three_x) * (2*W)'(three_x);
	assign jj_c  = (2*W)'(three_y) * (2*W)'(three_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= meas.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1s_s1 <= r1s_c;
			r2s_s1 <= r2s_c;
			r3s_s1 <= r3s_c;
			dd_s1  <= dd_c[CQW-1:0];
			ii_s1  <= ii_c[CQW-1:0];
			jj_s1  <= jj_c[CQW-1:0];
			r4_s1  <= meas.dist_four;
			bad_s1 <= (two_x == '0) || (three_y == '0);
		end
	end

	// ---- stage 2: x numerator and the part of the y numerator not needing x
	logic                  vld_s2, bad_s2;
	logic signed [NXW-1:0] numx_s2, numya_s2;
	logic [SQW-1:0]        r1s_s2;
	logic [W-2:0]          r4_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2  <= NXW'(dd_s1) + NXW'(r1s_s1) - NXW'(r2s_s1);
			numya_s2 <= NXW'(r1s_s1) - NXW'(r3s_s1) + NXW'(ii_s1) + NXW'(jj_s1);
			r1s_s2   <= r1s_s1;
			r4_s2    <= r4_s1;
			bad_s2   <= bad_s1;
		end
	end

	// ---- x = numx / (2 d), saturated
	logic                  vld_dx, bad_dx;
	logic signed [W-1:0]   x_dx;
	logic signed [NXW-1:0] numya_dx;
	logic [SQW-1:0]        r1s_dx;
	logic [W-2:0]          r4_dx;
	logic [SXW-1:0]        side_x;

	bt_div #(.W(W), .NW(NXW), .SW(SXW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.num      (numx_s2),
		.den      ($signed({two_x, 1'b0})),
		.in_side  ({numya_s2, r1s_s2, r4_s2, bad_s2}),
		.out_vld  (vld_dx),
		.quo      (x_dx),
		.out_side (side_x)
	);
	assign {numya_dx, r1s_dx, r4_dx, bad_dx} = side_x;

	// ---- stage 3: i * x
	logic                  vld_s3, bad_s3;
	logic signed [2*W-1:0] ix_s3;
	logic signed [W-1:0]   x_s3;
	logic signed [NXW-1:0] numya_s3;
	logic [SQW-1:0]        r1s_s3;
	logic [W-2:0]          r4_s3;

	logic signed [2*W-1:0] ix_c;
	assign ix_c = (2*W)'(three_x) * (2*W)'(x_dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_dx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s3    <= ix_c;
			x_s3     <= x_dx;
			numya_s3 <= numya_dx;
			r1s_s3   <= r1s_dx;
			r4_s3    <= r4_dx;
			bad_s3   <= bad_dx;
		end
	end

	// ---- stage 4: finish the y numerator
	logic                  vld_s4, bad_s4;
	logic signed [NYW-1:0] numy_s4;
	logic signed [W-1:0]   x_s4;
	logic [SQW-1:0]        r1s_s4;
	logic [W-2:0]          r4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numy_s4 <= NYW'(numya_s3) - (NYW'(ix_s3) <<< 1);
			x_s4    <= x_s3;
			r1s_s4  <= r1s_s3;
			r4_s4   <= r4_s3;
			bad_s4  <= bad_s3;
		end
	end

	// ---- y = numy / (2 j), saturated
	logic                vld_dy, bad_dy;
	logic signed [W-1:0] y_dy, x_dy;
	logic [SQW-1:0]      r1s_dy;
	logic [W-2:0]        r4_dy;
	logic [SYW-1:0]      side_y;

	bt_div #(.W(W), .NW(NYW), .SW(SYW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (numy_s4),
		.den      ($signed({three_y, 1'b0})),
		.in_side  ({x_s4, r1s_s4, r4_s4, bad_s4}),
		.out_vld  (vld_dy),
		.quo      (y_dy),
		.out_side (side_y)
	);
	assign {x_dy, r1s_dy, r4_dy, bad_dy} = side_y;

	// ---- stage 5: x^2 and y^2
	logic                vld_s5, bad_s5;
	logic [CQW-1:0]      xx_s5, yy_s5;
	logic signed [W-1:0] x_s5, y_s5;
	logic [SQW-1:0]      r1s_s5;
	logic [W-2:0]        r4_s5;

	logic signed [2*W-1:0] xx_c, yy_c;
	assign xx_c = (2*W)'(x_dy) * (2*W)'(x_dy);
	assign yy_c = (2*W)'(y_dy) * (2*W)'(y_dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_dy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s5  <= xx_c[CQW-1:0];
			yy_s5  <= yy_c[CQW-1:0];
			x_s5   <= x_dy;
			y_s5   <= y_dy;
			r1s_s5 <= r1s_dy;
			r4_s5  <= r4_dy;
			bad_s5 <= bad_dy;
		end
	end

	// ---- stage 6: radicand; a negative one means no real z
	logic                vld_s6, bad_s6, neg_s6;
	logic [SQW-1:0]      rad_s6;
	logic signed [W-1:0] x_s6, y_s6;
	logic [W-2:0]        r4_s6;

	logic [2*W:0] rad_c;
	assign rad_c = (2*W+1)'(r1s_s5) - (2*W+1)'(xx_s5) - (2*W+1)'(yy_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= rad_c[2*W];
			rad_s6 <= rad_c[2*W] ? '0 : rad_c[SQW-1:0];
			x_s6   <= x_s5;
			y_s6   <= y_s5;
			r4_s6  <= r4_s5;
			bad_s6 <= bad_s5;
		end
	end

	// ---- z = floor sqrt(radicand); never exceeds the word range
	logic                vld_sz, bad_sz, neg_sz;
	logic [W-2:0]        z_sz, r4_sz;
	logic signed [W-1:0] x_sz, y_sz;
	logic [SZW-1:0]      side_z;

	bt_sqrt #(.RW(SQW), .SW(SZW)) u_sqrt_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s6),
		.rad      (rad_s6),
		.in_side  ({x_s6, y_s6, r4_s6, neg_s6, bad_s6}),
		.out_vld  (vld_sz),
		.root     (z_sz),
		.out_side (side_z)
	);
	assign {x_sz, y_sz, r4_sz, neg_sz, bad_sz} = side_z;

	// ---- stage 7: offsets to beacon four for +z and -z
	logic                vld_s7, bad_s7, neg_s7;
	logic [W:0]          dx_s7, dy_s7, m1_s7, m2_s7;
	logic signed [W-1:0] x_s7, y_s7;
	logic [W-2:0]        z_s7, r4_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_sz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s7  <= (W+1)'(four_x) - (W+1)'(x_sz);
			dy_s7  <= (W+1)'(four_y) - (W+1)'(y_sz);
			m1_s7  <= (W+1)'(four_z) - (W+1)'(z_sz);
			m2_s7  <= (W+1)'(four_z) + (W+1)'(z_sz);
			x_s7   <= x_sz;
			y_s7   <= y_sz;
			z_s7   <= z_sz;
			r4_s7  <= r4_sz;
			neg_s7 <= neg_sz;
			bad_s7 <= bad_sz;
		end
	end

	// ---- stage 8: squares of the offsets
	logic                vld_s8, bad_s8, neg_s8;
	logic [DQW-1:0]      dx2_s8, dy2_s8, m12_s8, m22_s8;
	logic signed [W-1:0] x_s8, y_s8;
	logic [W-2:0]        z_s8, r4_s8;

	logic signed [2*W+1:0] dx2_c, dy2_c, m12_c, m22_c;
	assign dx2_c = (2*W+2)'($signed(dx_s7)) * (2*W+2)'($signed(dx_s7));
	assign dy2_c = (2*W+2)'($signed(dy_s7)) * (2*W+2)'($signed(dy_s7));
	assign m12_c = (2*W+2)'($signed(m1_s7)) * (2*W+2)'($signed(m1_s7));
	assign m22_c = (2*W+2)'($signed(m2_s7)) * (2*W+2)'($signed(m2_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s8 <= dx2_c[DQW-1:0];
			dy2_s8 <= dy2_c[DQW-1:0];
			m12_s8 <= m12_c[DQW-1:0];
			m22_s8 <= m22_c[DQW-1:0];
			x_s8   <= x_s7;
			y_s8   <= y_s7;
			z_s8   <= z_s7;
			r4_s8  <= r4_s7;
			neg_s8 <= neg_s7;
			bad_s8 <= bad_s7;
		end
	end

	// ---- stage 9: squared distances to beacon four
	logic                vld_s9, bad_s9, neg_s9;
	logic [FRW-1:0]      sum1_s9, sum2_s9;
	logic signed [W-1:0] x_s9, y_s9;
	logic [W-2:0]        z_s9, r4_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s9 <= 1'b0;
		else if (en) vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum1_s9 <= FRW'(dx2_s8) + FRW'(dy2_s8) + FRW'(m12_s8);
			sum2_s9 <= FRW'(dx2_s8) + FRW'(dy2_s8) + FRW'(m22_s8);
			x_s9    <= x_s8;
			y_s9    <= y_s8;
			z_s9    <= z_s8;
			r4_s9   <= r4_s8;
			neg_s9  <= neg_s8;
			bad_s9  <= bad_s8;
		end
	end

	// ---- both distances in parallel lanes; lane B carries dist_four
	logic                vld_fa, vld_fb, bad_fa, neg_fa;
	logic [W:0]          s1_fa, s2_fb;
	logic signed [W-1:0] x_fa, y_fa;
	logic [W-2:0]        z_fa, r4_fb;
	logic [SZW-1:0]      side_a;

	bt_sqrt #(.RW(FRW), .SW(SZW)) u_sqrt_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.rad      (sum1_s9),
		.in_side  ({x_s9, y_s9, z_s9, neg_s9, bad_s9}),
		.out_vld  (vld_fa),
		.root     (s1_fa),
		.out_side (side_a)
	);
	assign {x_fa, y_fa, z_fa, neg_fa, bad_fa} = side_a;

	bt_sqrt #(.RW(FRW), .SW(W - 1)) u_sqrt_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.rad      (sum2_s9),
		.in_side  (r4_s9),
		.out_vld  (vld_fb),
		.root     (s2_fb),
		.out_side (r4_fb)
	);

	// ---- stage 10: match errors against dist_four
	logic                vld_s10, bad_s10, neg_s10;
	logic [W:0]          a1_s10, a2_s10;
	logic signed [W-1:0] x_s10, y_s10;
	logic [W-2:0]        z_s10;

	logic signed [W+1:0] e1_c, e2_c;
	assign e1_c = (W+2)'(s1_fa) - (W+2)'(r4_fb);
	assign e2_c = (W+2)'(s2_fb) - (W+2)'(r4_fb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s10 <= 1'b0;
		else if (en) vld_s10 <= vld_fa & vld_fb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s10  <= e1_c[W+1] ? (W+1)'(-e1_c) : e1_c[W:0];
			a2_s10  <= e2_c[W+1] ? (W+1)'(-e2_c) : e2_c[W:0];
			x_s10   <= x_fa;
			y_s10   <= y_fa;
			z_s10   <= z_fa;
			neg_s10 <= neg_fa;
			bad_s10 <= bad_fa;
		end
	end

	// ---- result: pick the z sign, apply the special cases
	logic                flip;
	logic signed [W-1:0] px_c, py_c, pz_c;
	bt_pkg::status_t     st_c;

	// a tie keeps the positive z
	assign flip = use_fourth && (z_s10 != '0) && (a2_s10 < a1_s10);

	always_comb begin
		if (bad_s10) begin
			px_c = '0;
			py_c = '0;
			pz_c = '0;
			st_c = bt_pkg::ST_BAD_GEOM;
		end else if (neg_s10) begin
			px_c = x_s10;
			py_c = y_s10;
			pz_c = '0;
			st_c = bt_pkg::ST_NO_Z;
		end else begin
			px_c = x_s10;
			py_c = y_s10;
			pz_c = flip ? W'(0) - W'(z_s10) : W'(z_s10);
			st_c = bt_pkg::ST_OK;
		end
	end

	// ---- two-entry output buffer
	logic signed [W-1:0] px_q [2];
	logic signed [W-1:0] py_q [2];
	logic signed [W-1:0] pz_q [2];
	bt_pkg::status_t     st_q [2];
	logic                head_q;
	logic                push, pop, tail;

	assign push = en && vld_s10;
	assign pop  = position.valid && position.ready;
	assign tail = head_q ^ cnt_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) head_q <= ~head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			px_q[tail] <= px_c;
			py_q[tail] <= py_c;
			pz_q[tail] <= pz_c;
			st_q[tail] <= st_c;
		end
	end

	assign position.valid  = cnt_q != 2'd0;
	assign position.pos_x  = px_q[head_q];
	assign position.pos_y  = py_q[head_q];
	assign position.pos_z  = pz_q[head_q];
	assign position.status = st_q[head_q];

endmodule

// ===== design/bt_check.sv =====
module bt_check (
	input  logic     clk,
	input  logic     arst_n,
	bt_in_if.sink    meas,
	bt_out_if.source position
);

	// zero geometry gives an all-zero position
	a_bad_geom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		position.valid && position.status == bt_pkg::ST_BAD_GEOM |->
		position.pos_x == '0 && position.pos_y == '0 && position.pos_z == '0)
		else $error("bad geometry result not zeroed");

	// no real solution forces z to zero
	a_no_z_zero: assert property (@(posedge clk) disable iff (!arst_n)
		position.valid && position.status == bt_pkg::ST_NO_Z |-> position.pos_z == '0)
		else $error("no-solution result with nonzero z");

	// input only stalls while a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!meas.ready |-> position.valid)
		else $error("input stalled with no pending result");

	// a refused result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		position.valid && !position.ready |=>
		position.valid && $stable(position.pos_x) && $stable(position.pos_y) &&
		$stable(position.pos_z) && $stable(position.status))
		else $error("result beat changed while stalled");

endmodule

bind beacon_trilateration bt_check u_bt_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.meas     (meas),
	.position (position)
);
